// File: design/function_start_table_lookup_macros.svh
// assertion macros for the function-start table lookup checker
// expects clk and rst_n in the scope where a macro is used
`ifndef FUNCTION_START_TABLE_LOOKUP_MACROS_SVH
`define FUNCTION_START_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fsl_pkg.sv
// shared types and constants for the function-start table lookup
// no dependencies
package fsl_pkg;

    localparam int ADDR_W  = 64;
    localparam int SHIFT_W = 7;
    localparam int GROUP_W = 7;

    // result status codes
    typedef enum logic [1:0] {
        OUT_FOUND     = 2'd0,
        OUT_NOT_FOUND = 2'd1,
        OUT_OVERFLOW  = 2'd2
    } outcome_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODULE_BASE = 2'd0,
        CFG_TARGET_ADDR = 2'd1,
        CFG_TEXT_END    = 2'd2
    } cfg_index_t;

endpackage

// File: design/function_start_table_lookup.sv
// function-start table lookup: ULEB128 delta decode and range search
// depends on fsl_pkg
// throughput: one table byte per cycle unless stalled, in a single decode pass
// a result request passes the input register, then the result register;
// it holds on the port while stalled
// reset: asynchronous, clears decode, handshake and configuration registers to zero
module function_start_table_lookup (
    input  logic                 clk,
    input  logic                 rst_n,
    // table byte channel
    input  logic                 table_valid,
    output logic                 table_stall,
    input  logic [7:0]           table_byte,
    input  logic                 final_byte,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output fsl_pkg::outcome_t    outcome,
    output logic [63:0]          range_start,
    output logic [63:0]          range_limit,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  fsl_pkg::cfg_index_t  cfg_index,
    input  logic [63:0]          cfg_data
);
    import fsl_pkg::*;

    // configuration registers
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  target_reg;
    logic [ADDR_W-1:0]  text_end_reg;

    // input register
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_final_reg;

    // decode state
    logic [ADDR_W-1:0]  partial_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [ADDR_W-1:0]  offset_reg;
    logic [ADDR_W-1:0]  prior_reg;
    logic               have_prior_reg;
    logic               decided_reg;

    // result register
    logic               out_valid_reg;
    outcome_t           out_code_reg;
    logic [ADDR_W-1:0]  out_start_reg;
    logic [ADDR_W-1:0]  out_end_reg;

    // combinational step
    logic [GROUP_W-1:0] group;
    logic               more;
    logic               too_long;
    logic [ADDR_W-1:0]  shifted;
    logic [ADDR_W-1:0]  partial_new;
    logic               delta_zero;
    logic [ADDR_W:0]    offset_sum;
    logic [ADDR_W+1:0]  start_sum;
    logic               start_ovf;
    logic [ADDR_W-1:0]  start_addr;
    logic               in_prior_range;
    logic               store_start;
    logic [ADDR_W-1:0]  fin_prior;
    logic               fin_have;
    logic               fin_hit;
    logic               emit;
    outcome_t           emit_code;
    logic [ADDR_W-1:0]  emit_lo;
    logic [ADDR_W-1:0]  emit_hi;
    logic               out_free;
    logic               fire;
    logic               in_accept;

    // group extraction and the overlong check
    assign group    = in_byte_reg[GROUP_W-1:0];
    assign more     = in_byte_reg[7];
    assign too_long = (shift_reg >= SHIFT_W'(ADDR_W))
                   || ((shift_reg == SHIFT_W'(ADDR_W - 1)) && (group[GROUP_W-1:1] != '0));

    // shift-or of the new group into the partial value
    assign shifted     = {{(ADDR_W-GROUP_W){1'b0}}, group} << shift_reg[5:0];
    assign partial_new = partial_reg | shifted;
    assign delta_zero  = (partial_new == '0);

    // running offset and start address, summed in parallel
    assign offset_sum = {1'b0, offset_reg} + {1'b0, partial_new};
    assign start_sum  = {2'b00, base_reg} + {2'b00, offset_reg} + {2'b00, partial_new};
    assign start_ovf  = (start_sum[ADDR_W+1:ADDR_W] != 2'b00);
    assign start_addr = start_sum[ADDR_W-1:0];

    // range compares
    assign in_prior_range = have_prior_reg && (target_reg >= prior_reg)
                         && (target_reg < start_addr);
    assign store_start    = !decided_reg && !too_long && !more && !delta_zero
                         && !offset_sum[ADDR_W] && !start_ovf && !in_prior_range;
    assign fin_prior      = store_start ? start_addr : prior_reg;
    assign fin_have       = store_start || have_prior_reg;
    assign fin_hit        = fin_have && (target_reg >= fin_prior) && (target_reg < text_end_reg);

    // result decision for the byte in the input register
    always_comb
    begin
        emit      = 1'b0;
        emit_code = OUT_NOT_FOUND;
        emit_lo   = '0;
        emit_hi   = '0;
        if (!decided_reg)
        begin
            if (too_long)
            begin
                emit = 1'b1;
            end
            else if (more)
            begin
                emit = in_final_reg;
            end
            else if (delta_zero || offset_sum[ADDR_W] || start_ovf || in_prior_range)
            begin
                emit = 1'b1;
                if (delta_zero)
                begin
                    if (fin_hit)
                    begin
                        emit_code = OUT_FOUND;
                        emit_lo   = fin_prior;
                        emit_hi   = text_end_reg;
                    end
                end
                else if (offset_sum[ADDR_W] || start_ovf)
                begin
                    emit_code = OUT_OVERFLOW;
                end
                else
                begin
                    emit_code = OUT_FOUND;
                    emit_lo   = prior_reg;
                    emit_hi   = start_addr;
                end
            end
            else if (in_final_reg)
            begin
                emit = 1'b1;
                if (fin_hit)
                begin
                    emit_code = OUT_FOUND;
                    emit_lo   = fin_prior;
                    emit_hi   = text_end_reg;
                end
            end
        end
    end

    // handshake
    assign out_free    = !out_valid_reg || !result_stall;
    assign fire        = in_valid_reg && (!emit || out_free);
    assign table_stall = in_valid_reg && !fire;
    assign in_accept   = table_valid && !table_stall;
    assign cfg_ready   = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            target_reg   <= '0;
            text_end_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODULE_BASE: base_reg     <= cfg_data;
                CFG_TARGET_ADDR: target_reg   <= cfg_data;
                CFG_TEXT_END:    text_end_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= table_byte;
            in_final_reg <= final_byte;
        end
    end

    // decode state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            shift_reg      <= '0;
            offset_reg     <= '0;
            prior_reg      <= '0;
            have_prior_reg <= 1'b0;
            decided_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (in_final_reg)
            begin
                partial_reg    <= '0;
                shift_reg      <= '0;
                offset_reg     <= '0;
                prior_reg      <= '0;
                have_prior_reg <= 1'b0;
                decided_reg    <= 1'b0;
            end
            else if (!decided_reg)
            begin
                if (emit)
                begin
                    decided_reg <= 1'b1;
                end
                else if (more)
                begin
                    partial_reg <= partial_new;
                    shift_reg   <= SHIFT_W'(shift_reg + SHIFT_W'(GROUP_W));
                end
                else
                begin
                    partial_reg    <= '0;
                    shift_reg      <= '0;
                    offset_reg     <= offset_sum[ADDR_W-1:0];
                    prior_reg      <= start_addr;
                    have_prior_reg <= 1'b1;
                end
            end
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (out_free && fire && emit)
        begin
            out_code_reg  <= emit_code;
            out_start_reg <= emit_lo;
            out_end_reg   <= emit_hi;
        end
    end

    assign result_valid = out_valid_reg;
    assign outcome      = out_code_reg;
    assign range_start  = out_start_reg;
    assign range_limit  = out_end_reg;

endmodule

// File: design/fsl_checker.sv
// port-level checks for the function-start table lookup, bound to the top level
// depends on fsl_pkg and function_start_table_lookup_macros.svh
`include "function_start_table_lookup_macros.svh"

module fsl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_stall,
    input fsl_pkg::outcome_t    outcome,
    input logic [63:0]          range_start,
    input logic [63:0]          range_limit
);
    import fsl_pkg::*;

    // a stalled request keeps its payload
    `FSL_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(outcome) && $stable(range_start) && $stable(range_limit),
        "stalled result request changed")

    // only defined status codes leave the block
    `FSL_ASSERT_NOW(a_code_known, result_valid,
        outcome == OUT_FOUND || outcome == OUT_NOT_FOUND || outcome == OUT_OVERFLOW,
        "undefined outcome code")

    // a failed lookup reports an empty range
    `FSL_ASSERT_NOW(a_fail_zero, result_valid && outcome != OUT_FOUND,
        range_start == 64'd0 && range_limit == 64'd0,
        "range not cleared on failed lookup")

    // a found range is never empty
    `FSL_ASSERT_NOW(a_found_order, result_valid && outcome == OUT_FOUND,
        range_start < range_limit,
        "found range is empty or reversed")

endmodule

bind function_start_table_lookup fsl_checker u_fsl_checker (.*);

// File: test/function_start_table_lookup_tb.sv
// self-checking testbench for function_start_table_lookup: directed tables, then random ones
// depends on fsl_pkg and the function_start_table_lookup block; needs nothing else
module function_start_table_lookup_tb;

    import fsl_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam logic [63:0] ALL_ONES      = '1;
    // index 3 is not a register; writes to it must be dropped
    localparam cfg_index_t  CFG_UNUSED    = cfg_index_t'(2'd3);

    // one expected result request
    typedef struct packed {
        outcome_t    status;
        logic [63:0] lo;
        logic [63:0] hi;
    } fn_range_t;

    // decodes the delta table alongside the block and holds the ranges it must report
    class range_lookup_board;
        logic [63:0] base_addr;
        logic [63:0] target_addr;
        logic [63:0] end_addr;
        logic [63:0] partial;
        logic [63:0] offset_sum;
        logic [63:0] prior_start;
        logic [6:0]  shift;
        bit          have_prior;
        bit          decided;
        fn_range_t   expected_ranges[$];
        int unsigned mismatches;
        int unsigned bytes_used;
        int unsigned bytes_skipped;
        int unsigned outcome_seen[3];

        function new();
            base_addr     = '0;
            target_addr   = '0;
            end_addr      = '0;
            mismatches    = 0;
            bytes_used    = 0;
            bytes_skipped = 0;
            foreach (outcome_seen[i])
                outcome_seen[i] = 0;
            clear_table();
        endfunction

        function void clear_table();
            partial     = '0;
            offset_sum  = '0;
            prior_start = '0;
            shift       = '0;
            have_prior  = 1'b0;
            decided     = 1'b0;
        endfunction

        function void set_register(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_MODULE_BASE: base_addr   = value;
                CFG_TARGET_ADDR: target_addr = value;
                CFG_TEXT_END:    end_addr    = value;
                default: ;
            endcase
        endfunction

        function void issue_result(outcome_t status, logic [63:0] lo, logic [63:0] hi);
            fn_range_t r;
            r.status = status;
            r.lo     = lo;
            r.hi     = hi;
            expected_ranges.push_back(r);
            decided = 1'b1;
        endfunction

        // last function runs up to text_end
        function void close_table();
            if (have_prior && target_addr >= prior_start && target_addr < end_addr)
                issue_result(OUT_FOUND, prior_start, end_addr);
            else
                issue_result(OUT_NOT_FOUND, '0, '0);
        endfunction

        // note one accepted table byte request
        function void take_byte(logic [7:0] b, bit last);
            logic [63:0] grp;
            logic [63:0] delta;
            logic [64:0] sum;
            bit          more;
            grp  = {57'd0, b[6:0]};
            more = b[7];
            if (decided) begin
                bytes_skipped++;
            end else begin
                bytes_used++;
                if (shift >= 64 || ((grp << shift) >> shift) != grp) begin
                    issue_result(OUT_NOT_FOUND, '0, '0);
                end else begin
                    partial = partial | (grp << shift);
                    if (!more) begin
                        delta   = partial;
                        partial = '0;
                        shift   = '0;
                        sum     = {1'b0, offset_sum} + {1'b0, delta};
                        if (delta == 0) begin
                            close_table();
                        end else if (sum[64]) begin
                            issue_result(OUT_OVERFLOW, '0, '0);
                        end else begin
                            offset_sum = sum[63:0];
                            sum = {1'b0, base_addr} + {1'b0, offset_sum};
                            if (sum[64])
                                issue_result(OUT_OVERFLOW, '0, '0);
                            else if (have_prior && target_addr >= prior_start &&
                                     target_addr < sum[63:0])
                                issue_result(OUT_FOUND, prior_start, sum[63:0]);
                            else begin
                                prior_start = sum[63:0];
                                have_prior  = 1'b1;
                            end
                        end
                    end else begin
                        shift = shift + 7;
                    end
                    // table ends: cut-short value or last-range check
                    if (last && !decided) begin
                        if (more)
                            issue_result(OUT_NOT_FOUND, '0, '0);
                        else
                            close_table();
                    end
                end
            end
            if (last)
                clear_table();
        endfunction

        // compare one accepted result request with the oldest expectation
        function void check_range(outcome_t got_status, logic [63:0] got_lo,
                                  logic [63:0] got_hi);
            fn_range_t want;
            if (expected_ranges.size() == 0) begin
                $display("%0t: unexpected result: outcome %0d start %h limit %h",
                         $time, got_status, got_lo, got_hi);
                mismatches++;
                return;
            end
            want = expected_ranges.pop_front();
            outcome_seen[want.status]++;
            if (got_status !== want.status) begin
                $display("%0t: outcome expected %0d actual %0d", $time, want.status, got_status);
                mismatches++;
            end
            if (got_lo !== want.lo) begin
                $display("%0t: range_start expected %h actual %h", $time, want.lo, got_lo);
                mismatches++;
            end
            if (got_hi !== want.hi) begin
                $display("%0t: range_limit expected %h actual %h", $time, want.hi, got_hi);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        table_valid;
    logic        table_stall;
    logic [7:0]  table_byte;
    logic        final_byte;
    logic        result_valid;
    logic        result_stall;
    outcome_t    outcome;
    logic [63:0] range_start;
    logic [63:0] range_limit;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [63:0] cfg_data;

    range_lookup_board sb = new();
    logic [7:0]        table_bytes[$];
    int unsigned       gap_max;
    int unsigned       burst_left;
    int unsigned       tables_sent;
    int unsigned       settings_used;
    bit                hold_off;

    function_start_table_lookup uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_valid  (table_valid),
        .table_stall  (table_stall),
        .table_byte   (table_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .outcome      (outcome),
        .range_start  (range_start),
        .range_limit  (range_limit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.expected_ranges.size());
        $display("tb: failure");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
            sb.check_range(outcome, range_start, range_limit);
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        int unsigned tick;
        mode    = 0;
        stretch = 0;
        tick    = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            tick++;
            case (mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 99) < 30);
                2: result_stall <= ($urandom_range(0, 99) < 80);
                default: result_stall <= ((tick % 8) < 5);
            endcase
        end
    end

    // one register write; valid is dropped after the write is taken
    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one table byte request, in bursts with random gaps
    task automatic send_byte(logic [7:0] b, bit last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                table_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        table_valid <= 1'b1;
        table_byte  <= b;
        final_byte  <= last;
        do @(posedge clk); while (table_stall !== 1'b0);
        sb.take_byte(b, last);
        burst_left--;
    endtask

    task automatic send_table();
        foreach (table_bytes[i])
            send_byte(table_bytes[i], i == table_bytes.size() - 1);
        tables_sent++;
    endtask

    // wait for every expected result, then let the pipeline empty
    task automatic settle();
        table_valid <= 1'b0;
        while (sb.expected_ranges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ULEB128 encoding, optionally padded with redundant zero groups (ten groups at most)
    function automatic void push_uleb(logic [63:0] value, int unsigned pad);
        logic [63:0] rest;
        int unsigned groups;
        rest   = value;
        groups = 1;
        while ((rest >> 7) != 0)
        begin
            rest = rest >> 7;
            groups++;
        end
        groups = groups + pad;
        if (groups > 10)
            groups = 10;
        rest = value;
        for (int unsigned i = 0; i < groups; i++)
        begin
            table_bytes.push_back({i + 1 != groups, rest[6:0]});
            rest = rest >> 7;
        end
    endfunction

    // mostly well-formed tables, the rest huge deltas, overlong or cut-short values and noise
    function automatic void build_random_table();
        int unsigned kind;
        int unsigned roll;
        int unsigned ending;
        logic [63:0] delta;
        table_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            repeat ($urandom_range(1, 10))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                    delta = $urandom_range(1, 600);
                else if (roll < 95)
                    delta = $urandom_range(1, 1 << 20);
                else
                    delta = {$urandom, $urandom};
                push_uleb(delta, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
            end
            ending = $urandom_range(0, 3);
            if (ending == 0)
                table_bytes.push_back(8'h00);
            if (ending <= 1)
                repeat ($urandom_range(0, 3)) table_bytes.push_back(8'($urandom));
        end
        else if (kind < 70)
        begin
            repeat ($urandom_range(1, 4))
                push_uleb(($urandom_range(0, 4) == 0) ? 64'h8000_0000_0000_0000
                                                      : {$urandom, $urandom}, 0);
        end
        else if (kind < 80)
        begin
            // zero groups run on past bit 63, random ones spill over it
            repeat ($urandom_range(0, 2)) push_uleb($urandom_range(1, 600), 0);
            repeat ($urandom_range(10, 12))
                table_bytes.push_back(8'h80 | ($urandom_range(0, 1) ? 8'($urandom) : 8'h00));
            table_bytes.push_back(8'($urandom));
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(0, 3)) push_uleb($urandom_range(1, 600), 0);
            repeat ($urandom_range(1, 3)) table_bytes.push_back(8'h80 | 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 8)) table_bytes.push_back(8'($urandom));
        end
    endfunction

    // register values for one random setting; first two are the extremes
    task automatic load_setting(int unsigned setting_no);
        logic [63:0] values[3];
        cfg_index_t  order[3];
        int unsigned roll;
        int unsigned rot;
        order = '{CFG_MODULE_BASE, CFG_TARGET_ADDR, CFG_TEXT_END};
        if (setting_no == 1)
            values = '{64'd0, 64'd0, 64'd0};
        else if (setting_no == 2)
            values = '{ALL_ONES, ALL_ONES, ALL_ONES};
        else
        begin
            roll = $urandom_range(0, 9);
            if (roll < 2)
                values[0] = {$urandom, $urandom};
            else if (roll < 4)
                values[0] = ALL_ONES - $urandom_range(0, 3000);
            else if (roll < 5)
                values[0] = '0;
            else
                values[0] = {32'd0, $urandom};
            roll = $urandom_range(0, 9);
            if (roll < 7)
                values[1] = values[0] + $urandom_range(0, 4000);
            else if (roll < 8)
                values[1] = {$urandom, $urandom};
            else if (roll < 9)
                values[1] = '0;
            else
                values[1] = ALL_ONES;
            roll = $urandom_range(0, 9);
            if (roll < 6)
                values[2] = values[1] + $urandom_range(1, 3000);
            else if (roll < 7)
                values[2] = values[1];
            else if (roll < 8)
                values[2] = {$urandom, $urandom};
            else if (roll < 9)
                values[2] = ALL_ONES;
            else
                values[2] = values[0] + $urandom_range(0, 2000);
        end
        rot = $urandom_range(0, 2);
        for (int unsigned k = 0; k < 3; k++)
            write_reg(order[(k + rot) % 3], values[(k + rot) % 3]);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        int unsigned directed_bytes;
        int unsigned setting_no;
        rst_n       <= 1'b0;
        table_valid <= 1'b0;
        table_byte  <= 8'h00;
        final_byte  <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_MODULE_BASE;
        cfg_data    <= '0;
        gap_max       = 0;
        burst_left    = 0;
        tables_sent   = 0;
        settings_used = 0;
        hold_off      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: target between the first two starts of a small module
        write_reg(CFG_MODULE_BASE, 64'h1000);
        write_reg(CFG_TARGET_ADDR, 64'h1050);
        write_reg(CFG_TEXT_END, 64'h2000);
        write_reg(CFG_UNUSED, ALL_ONES);
        settings_used++;
        // found between two starts, trailing byte ignored
        table_bytes = '{8'h10, 8'h80, 8'h01, 8'hff};
        send_table();
        // zero delta closes the table early
        table_bytes = '{8'h10, 8'h00, 8'h7f};
        send_table();
        // last range closed by text_end on the final byte
        table_bytes = '{8'h10};
        send_table();
        // final byte still has its continuation bit
        table_bytes = '{8'h90};
        send_table();
        // table ends before any start
        table_bytes = '{8'h00};
        send_table();
        // group spills past bit 63
        table_bytes.delete();
        repeat (9) table_bytes.push_back(8'h80);
        table_bytes.push_back(8'h02);
        send_table();
        settle();

        // directed: start address wraps past the top of the address space
        write_reg(CFG_MODULE_BASE, 64'hffff_ffff_ffff_fff0);
        write_reg(CFG_TARGET_ADDR, ALL_ONES);
        write_reg(CFG_TEXT_END, ALL_ONES);
        settings_used++;
        table_bytes = '{8'h20};
        send_table();
        settle();

        // random settings, each with a batch of tables
        directed_bytes = sb.bytes_used + sb.bytes_skipped;
        setting_no = 0;
        while (sb.bytes_used + sb.bytes_skipped - directed_bytes < RANDOM_ITEMS)
        begin
            setting_no++;
            load_setting(setting_no);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            burst_left = 0;
            if (setting_no == 3)
                hold_off = 1'b1;
            repeat ($urandom_range(4, 12))
            begin
                build_random_table();
                send_table();
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d tables under %0d register settings, %0d bytes decoded, %0d skipped",
                 tables_sent, settings_used, sb.bytes_used, sb.bytes_skipped);
        $display("summary: results found %0d, not found %0d, overflow %0d, mismatches %0d",
                 sb.outcome_seen[OUT_FOUND], sb.outcome_seen[OUT_NOT_FOUND],
                 sb.outcome_seen[OUT_OVERFLOW], sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_ranges.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
